// ===== rtl/nlp_pkg.sv =====
`default_nettype none

package nlp_pkg;

    localparam int CharW  = 8;
    localparam int AccumW = 17;
    localparam int DigitW = 4;

    // Character codes
    localparam logic [CharW-1:0] CH_MINUS   = 8'h2D;
    localparam logic [CharW-1:0] CH_ZERO    = 8'h30;
    localparam logic [CharW-1:0] CH_SEVEN   = 8'h37;
    localparam logic [CharW-1:0] CH_NINE    = 8'h39;
    localparam logic [CharW-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CharW-1:0] CH_UPPER_F = 8'h46;
    localparam logic [CharW-1:0] CH_UPPER_X = 8'h58;
    localparam logic [CharW-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CharW-1:0] CH_LOWER_F = 8'h66;
    localparam logic [CharW-1:0] CH_LOWER_X = 8'h78;

    // Per-digit overflow guards and final range limits
    localparam logic [AccumW-1:0] GUARD_DEC = 17'd6553;
    localparam logic [AccumW-1:0] GUARD_OCT = 17'd8191;
    localparam logic [AccumW-1:0] GUARD_HEX = 17'd4095;
    localparam logic [AccumW-1:0] LIMIT_NEG = 17'd32768;

    typedef enum logic [7:0] {
        PH_START  = 8'b0000_0001,
        PH_SIGNED = 8'b0000_0010,
        PH_ZERO   = 8'b0000_0100,
        PH_HEXPRE = 8'b0000_1000,
        PH_OCT    = 8'b0001_0000,
        PH_DEC    = 8'b0010_0000,
        PH_HEX    = 8'b0100_0000,
        PH_REJECT = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        phase_t              phase;
        logic                negative;
        logic [AccumW-1:0]   accum;
    } parse_state_t;

    typedef struct packed {
        logic                accepted;
        logic [AccumW-1:0]   number;
    } verdict_t;

    localparam parse_state_t STATE_RESET = '{phase: PH_START, negative: 1'b0, accum: '0};

    // {valid, value} of a hex digit character
    function automatic logic [DigitW:0] hex_digit(input logic [CharW-1:0] c);
        logic [DigitW:0] r;
        r = '0;
        if (c >= CH_ZERO && c <= CH_NINE)
            r = {1'b1, c[DigitW-1:0]};
        else if ((c >= CH_LOWER_A && c <= CH_LOWER_F) || (c >= CH_UPPER_A && c <= CH_UPPER_F))
            r = {1'b1, c[DigitW-1:0] + 4'd9};
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/nlp_step.sv =====
`default_nettype none

module nlp_step (
    input  nlp_pkg::parse_state_t          cur,
    input  logic [nlp_pkg::CharW-1:0]      char_code,
    input  logic                           end_mark,
    output nlp_pkg::parse_state_t          nxt,
    output nlp_pkg::verdict_t              verdict
);
    import nlp_pkg::*;

    logic                is_dec;
    logic                is_oct;
    logic [DigitW:0]     hex;
    logic [AccumW-1:0]   dec_acc;
    logic [AccumW-1:0]   oct_acc;
    logic [AccumW-1:0]   hex_acc;
    logic [AccumW-1:0]   digit;
    parse_state_t        take;
    logic                ok;

    assign is_dec = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign is_oct = (char_code >= CH_ZERO) && (char_code <= CH_SEVEN);
    assign hex    = hex_digit(char_code);
    assign digit  = {{(AccumW-DigitW){1'b0}}, char_code[DigitW-1:0]};

    // accum * 10 as (accum << 3) + (accum << 1), wrapped to the accumulator width
    assign dec_acc = {cur.accum[AccumW-4:0], 3'b000} + {cur.accum[AccumW-2:0], 1'b0} + digit;
    assign oct_acc = {cur.accum[AccumW-4:0], char_code[2:0]};
    assign hex_acc = {cur.accum[AccumW-5:0], hex[DigitW-1:0]};

    always_comb
    begin
        take = cur;
        unique case (cur.phase)
            PH_START, PH_SIGNED:
            begin
                if (cur.phase == PH_START && char_code == CH_MINUS)
                begin
                    take.negative = 1'b1;
                    take.phase    = PH_SIGNED;
                end
                else if (char_code == CH_ZERO)
                    take.phase = PH_ZERO;
                else if (is_dec)
                begin
                    take.accum = digit;
                    take.phase = PH_DEC;
                end
                else
                    take.phase = PH_REJECT;
            end
            PH_ZERO:
            begin
                if (char_code == CH_LOWER_X || char_code == CH_UPPER_X)
                    take.phase = PH_HEXPRE;
                else if (is_oct)
                begin
                    take.accum = digit;
                    take.phase = PH_OCT;
                end
                else
                    take.phase = PH_REJECT;
            end
            PH_HEXPRE:
            begin
                if (hex[DigitW])
                begin
                    take.accum = {{(AccumW-DigitW){1'b0}}, hex[DigitW-1:0]};
                    take.phase = PH_HEX;
                end
                else
                    take.phase = PH_REJECT;
            end
            PH_OCT:
            begin
                if (!is_oct || cur.accum > GUARD_OCT)
                    take.phase = PH_REJECT;
                else
                    take.accum = oct_acc;
            end
            PH_DEC:
            begin
                if (!is_dec || cur.accum > GUARD_DEC)
                    take.phase = PH_REJECT;
                else
                    take.accum = dec_acc;
            end
            PH_HEX:
            begin
                if (!hex[DigitW] || cur.accum > GUARD_HEX)
                    take.phase = PH_REJECT;
                else
                    take.accum = hex_acc;
            end
            default:
                take.phase = PH_REJECT;
        endcase
    end

    // Verdict on the end marker: a number phase, then the range check
    always_comb
    begin
        ok = (cur.phase == PH_ZERO) || (cur.phase == PH_OCT) ||
             (cur.phase == PH_DEC)  || (cur.phase == PH_HEX);
        if (cur.accum[AccumW-1] || (cur.negative && cur.accum > LIMIT_NEG))
            ok = 1'b0;
        verdict.accepted = ok;
        if (!ok)
            verdict.number = '0;
        else if (cur.negative)
            verdict.number = '0 - cur.accum;
        else
            verdict.number = cur.accum;
    end

    assign nxt = end_mark ? STATE_RESET : take;

endmodule

`default_nettype wire

// ===== rtl/numeric_literal_parser.sv =====
`default_nettype none

// Channel   Dir  Signals                         Content
// s_axis    in   tvalid tready tdata[7:0] tlast  one character; tlast = end marker
// m_axis    out  tvalid tready tdata[23:0] tuser verdict per end marker
//
// Each item is registered, stepped through the parser as it leaves the input
// register and, for an end marker, written to the result register: one item
// per cycle, stalls apart. The parse state register is the only loop.
// Reset (rst_n low, asynchronous) empties both registers and returns the
// parser to the start of a text. A stalled result holds only end markers
// back; plain characters keep flowing while it waits.
module numeric_literal_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
    input  logic        s_axis_tlast,   // end_mark
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [16:0] number (signed), [23:17] zero
    output logic        m_axis_tuser    // accepted
);
    import nlp_pkg::*;

    logic               in_vld_reg;
    logic [CharW-1:0]   in_char_reg;
    logic               in_last_reg;
    logic               out_vld_reg;
    verdict_t           out_reg;
    parse_state_t       state_reg;
    parse_state_t       state_next;
    verdict_t           verdict;
    logic               out_free;
    logic               stage_fire;
    logic               in_take;

    // Input stage drains when the item is a character, or the result slot is free
    assign out_free      = !out_vld_reg || m_axis_tready;
    assign stage_fire    = in_vld_reg && (!in_last_reg || out_free);
    assign s_axis_tready = !in_vld_reg || stage_fire;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    nlp_step u_step (
        .cur       (state_reg),
        .char_code (in_char_reg),
        .end_mark  (in_last_reg),
        .nxt       (state_next),
        .verdict   (verdict)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
            state_reg   <= STATE_RESET;
        end
        else
        begin
            if (in_take)
                in_vld_reg <= 1'b1;
            else if (stage_fire)
                in_vld_reg <= 1'b0;

            if (stage_fire && in_last_reg)
                out_vld_reg <= 1'b1;
            else if (m_axis_tready)
                out_vld_reg <= 1'b0;

            // advance the parser on every item that leaves the input stage
            if (stage_fire)
                state_reg <= state_next;
        end
    end

    // Payload: hold until the next load
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (stage_fire && in_last_reg)
            out_reg <= verdict;
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tuser  = out_reg.accepted;
    assign m_axis_tdata  = {{(24-AccumW){1'b0}}, out_reg.number};

    // An end marker must not overwrite a result that is still waiting
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (in_vld_reg && in_last_reg && out_vld_reg && !m_axis_tready) |-> !stage_fire)
        else $error("end marker taken while result stalled");

    // The parser starts over after every end marker
    a_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (stage_fire && in_last_reg) |=> (state_reg == STATE_RESET))
        else $error("parser not restarted after end marker");

    // A rejected text reports zero
    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == 24'd0))
        else $error("rejected text with non-zero number");

    // A negative result never lies below -32768
    a_neg_range: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser && m_axis_tdata[16]) |-> m_axis_tdata[15])
        else $error("negative result out of range");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
    import nlp_pkg::*;

    localparam int ITEM_TARGET = 1800;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int REPORT_MAX  = 10;
    localparam int DRAIN_WAIT  = 8;
    localparam int RESET_LEN   = 10;

    localparam logic [AccumW-1:0] MAX_MAGNITUDE = 17'd65535;
    // flips the case of a letter
    localparam logic [CharW-1:0]  CASE_BIT      = 8'h20;

    typedef logic [CharW-1:0] text_t[$];

    // Parser predictor plus the queue of verdicts still owed by the block
    class verdict_board;
        phase_t            phase;
        logic              negative;
        logic [AccumW-1:0] accum;
        verdict_t          owed_q[$];
        int                mismatches;
        int                verdicts;
        int                accepts;

        function new();
            restart();
        endfunction

        function void restart();
            phase    = PH_START;
            negative = 1'b0;
            accum    = '0;
        endfunction

        function int hex_value(logic [CharW-1:0] c);
            if (c >= CH_ZERO && c <= CH_NINE)
                return int'(c - CH_ZERO);
            if (c >= CH_LOWER_A && c <= CH_LOWER_F)
                return int'(c - CH_LOWER_A) + 10;
            if (c >= CH_UPPER_A && c <= CH_UPPER_F)
                return int'(c - CH_UPPER_A) + 10;
            return -1;
        endfunction

        // Step the parse state over one character
        function void advance(logic [CharW-1:0] c);
            logic              dec;
            int                h;
            logic [AccumW-1:0] d;
            dec = (c >= CH_ZERO && c <= CH_NINE);
            h   = hex_value(c);
            d   = AccumW'(c - CH_ZERO);
            case (phase)
                PH_START, PH_SIGNED:
                begin
                    if (phase == PH_START && c == CH_MINUS)
                    begin
                        negative = 1'b1;
                        phase    = PH_SIGNED;
                    end
                    else if (c == CH_ZERO)
                        phase = PH_ZERO;
                    else if (dec)
                    begin
                        accum = d;
                        phase = PH_DEC;
                    end
                    else
                        phase = PH_REJECT;
                end
                PH_ZERO:
                begin
                    if (c == CH_LOWER_X || c == CH_UPPER_X)
                        phase = PH_HEXPRE;
                    else if (c >= CH_ZERO && c <= CH_SEVEN)
                    begin
                        accum = d;
                        phase = PH_OCT;
                    end
                    else
                        phase = PH_REJECT;
                end
                PH_HEXPRE:
                begin
                    if (h < 0)
                        phase = PH_REJECT;
                    else
                    begin
                        accum = AccumW'(h);
                        phase = PH_HEX;
                    end
                end
                PH_OCT:
                begin
                    if (c < CH_ZERO || c > CH_SEVEN || accum > GUARD_OCT)
                        phase = PH_REJECT;
                    else
                        accum = (accum << 3) | d;
                end
                PH_DEC:
                begin
                    if (!dec || accum > GUARD_DEC)
                        phase = PH_REJECT;
                    else
                        accum = accum * 17'd10 + d;
                end
                PH_HEX:
                begin
                    if (h < 0 || accum > GUARD_HEX)
                        phase = PH_REJECT;
                    else
                        accum = (accum << 4) | AccumW'(h);
                end
                default:
                    phase = PH_REJECT;
            endcase
        endfunction

        // Note an accepted input item; returns 0 for a character the parser ignores
        function bit note_input(logic [CharW-1:0] c, logic last);
            bit       live;
            logic     ok;
            verdict_t v;
            if (!last)
            begin
                live = (phase != PH_REJECT);
                advance(c);
                return live;
            end
            ok = (phase == PH_ZERO || phase == PH_OCT || phase == PH_DEC || phase == PH_HEX);
            if (accum > MAX_MAGNITUDE || (negative && accum > LIMIT_NEG))
                ok = 1'b0;
            v.accepted = ok;
            v.number   = !ok ? '0 : (negative ? 17'd0 - accum : accum);
            owed_q.push_back(v);
            restart();
            return 1'b1;
        endfunction

        function void report(string what);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("[%0t] MISMATCH %s", $time, what);
        endfunction

        // Compare one verdict from the block with the oldest one owed
        function void check_result(logic accepted, logic [23:0] data);
            verdict_t want;
            if (owed_q.size() == 0)
            begin
                report($sformatf("unexpected verdict accepted=%0b data=%h", accepted, data));
                return;
            end
            want = owed_q.pop_front();
            verdicts++;
            if (want.accepted)
                accepts++;
            if (accepted !== want.accepted || data[AccumW-1:0] !== want.number ||
                data[23:AccumW] !== '0)
                report($sformatf("verdict %0d: expected accepted=%0b number=%0d, got accepted=%0b number=%0d pad=%h",
                                 verdicts, want.accepted, $signed(want.number), accepted,
                                 $signed(data[AccumW-1:0]), data[23:AccumW]));
        endfunction

        function int pending();
            return owed_q.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;     // [7:0] char_code
    logic        s_axis_tlast = 1'b0;   // end_mark
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;          // [16:0] number (signed), [23:17] zero
    logic        m_axis_tuser;          // accepted

    verdict_board board;
    int           live_items;
    int           char_count;
    int           text_count;
    int           cycles;
    int           stall_left;
    logic         sink_calm = 1'b0;

    numeric_literal_parser uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 clk = ~clk;

    // Mostly no gap or a short one, now and then a long one
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Result side: random stalls, with calm stretches where tready stays high
    always @(posedge clk)
    begin
        if ($urandom_range(0, 299) == 0)
            sink_calm <= !sink_calm;
        if (stall_left != 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else if (!sink_calm && $urandom_range(0, 99) < 30)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= idle_length();
        end
        else
            m_axis_tready <= 1'b1;
    end

    // Check every verdict the block hands over
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            board.check_result(m_axis_tuser, m_axis_tdata);
    end

    // Watchdog: stop a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[%0t] timeout after %0d cycles, %0d verdicts still owed",
                     $time, cycles, board.pending());
            $display("Some tests failed");
            $finish;
        end
    end

    // Present one item and hold it until the block takes it. Valid stays high
    // between back-to-back items; it is only dropped when a gap is inserted.
    task automatic send_item(input logic [7:0] c, input logic last, input bit calm);
        int gap;
        gap = calm ? 0 : idle_length();
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (board.note_input(c, last))
            live_items++;
        if (!last)
            char_count++;
    endtask

    // Send the body, then the end marker with a random (ignored) character
    task automatic send_text(input text_t body);
        bit calm;
        calm = ($urandom_range(0, 99) < 20);
        foreach (body[i])
            send_item(body[i], 1'b0, calm);
        send_item(8'($urandom_range(0, 255)), 1'b1, calm);
        text_count++;
    endtask

    function automatic text_t to_text(string s);
        text_t t;
        for (int i = 0; i < s.len(); i++)
            t.push_back(s[i]);
        return t;
    endfunction

    // Format a value as a literal: decimal, octal or hex, letters in mixed case
    function automatic text_t literal_text(int unsigned value, int radix, bit minus);
        text_t      t;
        string      digits;
        logic [7:0] c;
        if (minus)
            t.push_back(CH_MINUS);
        case (radix)
            0:
                digits = $sformatf("%0d", value);
            1:
            begin
                t.push_back(CH_ZERO);
                digits = $sformatf("%0o", value);
            end
            default:
            begin
                t.push_back(CH_ZERO);
                t.push_back($urandom_range(0, 1) ? CH_LOWER_X : CH_UPPER_X);
                // leading zeros after the prefix
                if ($urandom_range(0, 9) == 0)
                    repeat ($urandom_range(1, 3)) t.push_back(CH_ZERO);
                digits = $sformatf("%0h", value);
            end
        endcase
        for (int i = 0; i < digits.len(); i++)
        begin
            c = digits[i];
            if (c >= CH_LOWER_A && c <= CH_LOWER_F && $urandom_range(0, 1))
                c = c ^ CASE_BIT;
            t.push_back(c);
        end
        return t;
    endfunction

    // Bias values towards the range limits and past the overflow guards
    function automatic int unsigned pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35)
            return $urandom_range(0, 65535);
        if (r < 55)
            return $urandom_range(0, 255);
        if (r < 75)
            return ($urandom_range(0, 1) ? 65530 : 32763) + $urandom_range(0, 10);
        return $urandom_range(65536, 2000000);
    endfunction

    function automatic logic [7:0] stray_char();
        case ($urandom_range(0, 4))
            0: return CH_MINUS;
            1: return CH_NINE;
            2: return CH_UPPER_X;
            3: return CH_LOWER_F;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed literals; the rest damaged literals, noise and short oddities
    function automatic text_t random_text();
        text_t t;
        int    r;
        int    pos;
        r = $urandom_range(0, 99);
        if (r < 80)
            t = literal_text(pick_value(), $urandom_range(0, 2), $urandom_range(0, 99) < 30);
        if (r >= 65 && r < 80)
        begin
            pos = $urandom_range(0, t.size());
            if ($urandom_range(0, 1) || pos == t.size())
                t.insert(pos, stray_char());
            else
                t[pos] = stray_char();
        end
        else if (r >= 80 && r < 92)
        begin
            repeat ($urandom_range(1, 6))
            begin
                case ($urandom_range(0, 2))
                    0: t.push_back(8'($urandom_range(0, 255)));
                    1: t.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                    default: t.push_back(stray_char());
                endcase
            end
        end
        else if (r >= 92)
        begin
            case ($urandom_range(0, 5))
                0: t = {};
                1: t = to_text("-");
                2: t = to_text("0x");
                3: t = to_text("-0X");
                4: t = to_text("0");
                default: t = to_text("-0");
            endcase
        end
        return t;
    endfunction

    initial
    begin
        text_t t;
        board = new();
        repeat (RESET_LEN) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed texts: empty, lone sign, minus zero, bare hex prefix, 9 after
        // a leading zero, a stray byte, NUL, the range edges and mixed-case hex
        send_text(to_text(""));
        send_text(to_text("-"));
        send_text(to_text("-0"));
        send_text(to_text("0X"));
        send_text(to_text("09"));
        t = to_text("1");
        t.push_back(8'hFF);
        send_text(t);
        t = {};
        t.push_back(8'h00);
        send_text(t);
        send_text(to_text("65535"));
        send_text(to_text("-32768"));
        send_text(to_text("0xaBcD"));

        // Random texts
        while (live_items < ITEM_TARGET)
            send_text(random_text());
        s_axis_tvalid <= 1'b0;

        // Drain: wait for every verdict owed, then let the pipeline settle
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Sent %0d texts (%0d characters); checked %0d verdicts, %0d of them accepted.",
                 text_count, char_count, board.verdicts, board.accepts);
        $display("Mismatches: %0d, verdicts still owed: %0d", board.mismatches, board.pending());
        if (board.mismatches == 0 && board.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
